// ===== design/charge_weighted_phase_sincos_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the charge-weighted phase sin/cos block
// Clocked assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef CHARGE_WEIGHTED_PHASE_SINCOS_TOP_ASSERT_SVH
`define CHARGE_WEIGHTED_PHASE_SINCOS_TOP_ASSERT_SVH

// Property checked outside reset.
`define CWPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CWPS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cwps_pkg.sv =====
// ----------------------------------------------------------------------------
// cwps_pkg
// Request types, CORDIC constants and register indexes.
// ----------------------------------------------------------------------------
package cwps_pkg;

  localparam int CFG_INDEX_W  = 2;
  localparam int CORDIC_STEPS = 24;
  localparam int XY_W         = 34;
  localparam int Z_W          = 33;

  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_Z = 2'd2;

  localparam logic signed [XY_W-1:0] CORDIC_X0  = 34'sd652032874;
  localparam logic signed [XY_W-1:0] ONE_Q30    = 34'sd1073741824;
  localparam logic [31:0]            EIGHTH_TURN = 32'h2000_0000;
  localparam logic signed [63:0]     ROUND_HALF = 64'sd536870912;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] charge;
  } atom_t;

  typedef struct packed {
    logic signed [31:0] cos_term;
    logic signed [31:0] sin_term;
  } density_t;

  typedef struct packed {
    logic                   valid;
    quad_t                  quad;
    logic signed [31:0]     charge;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_stage_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    case (i)
      0:       return 32'h20000000;
      1:       return 32'h12E4051E;
      2:       return 32'h09FB385B;
      3:       return 32'h051111D4;
      4:       return 32'h028B0D43;
      5:       return 32'h0145D7E1;
      6:       return 32'h00A2F61E;
      7:       return 32'h00517C55;
      8:       return 32'h0028BE53;
      9:       return 32'h00145F2F;
      10:      return 32'h000A2F98;
      11:      return 32'h000517CC;
      12:      return 32'h00028BE6;
      13:      return 32'h000145F3;
      14:      return 32'h0000A2F9;
      15:      return 32'h0000517C;
      16:      return 32'h000028BE;
      17:      return 32'h0000145F;
      18:      return 32'h00000A2F;
      19:      return 32'h00000517;
      20:      return 32'h0000028B;
      21:      return 32'h00000145;
      22:      return 32'h000000A2;
      23:      return 32'h00000051;
      default: return 32'h00000000;
    endcase
  endfunction

endpackage

// ===== design/cwps_cordic.sv =====
// ----------------------------------------------------------------------------
// cwps_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module cwps_cordic (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  cwps_pkg::cordic_stage_t in_stage,
  output cwps_pkg::cordic_stage_t out_stage
);
  import cwps_pkg::*;

  cordic_stage_t st [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cordic_stage_t         cur;
    cordic_stage_t         nxt;
    logic signed [Z_W-1:0] ang;

    if (i == 0) begin : g_first
      assign cur = in_stage;
    end else begin : g_rest
      assign cur = st[i-1];
    end

    always_comb begin
      ang = $signed({1'b0, atan_turn(i)});
      nxt = cur;
      if (!cur.z[Z_W-1]) begin
        nxt.x = cur.x - ($signed(cur.y) >>> i);
        nxt.y = cur.y + ($signed(cur.x) >>> i);
        nxt.z = cur.z - ang;
      end else begin
        nxt.x = cur.x + ($signed(cur.y) >>> i);
        nxt.y = cur.y - ($signed(cur.x) >>> i);
        nxt.z = cur.z + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[i].valid <= 1'b0;
      end else if (adv) begin
        st[i] <= nxt;
      end
    end
  end

  assign out_stage = st[CORDIC_STEPS-1];

endmodule

// ===== design/charge_weighted_phase_sincos_top.sv =====
// ----------------------------------------------------------------------------
// charge_weighted_phase_sincos_top
// Takes one atom request per cycle and returns charge*cos and charge*sin of
// the phase 2*pi*(w . r), both signed Q8.24 and saturated. The phase is the
// fractional turn of the dot product with the wave vector registers, cut to
// ANGLE_BITS bits. Sustained rate is one request per clock while in_stall is
// low; the depth is set by the 24-stage CORDIC pipeline plus the dot-product,
// angle, quadrant, multiply and output stages. The whole pipeline advances
// together; a one-entry skid behind the output register absorbs the result
// in flight when the output stalls, and in_stall rises only once that skid
// is full. Write the wave registers only while the pipeline is empty.
// ----------------------------------------------------------------------------
module charge_weighted_phase_sincos_top #(
  parameter int ANGLE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cwps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cwps_pkg::atom_t                    in_req,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cwps_pkg::density_t                 out_req
);
  import cwps_pkg::*;

  localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  function automatic logic signed [31:0] clamp_unit(input logic signed [XY_W-1:0] v);
    if (v > ONE_Q30) return 32'(ONE_Q30);
    if (v < -ONE_Q30) return 32'(-ONE_Q30);
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic signed [33:0] r;
    s = p + ROUND_HALF;
    r = s[63:30];
    if (r > 34'sd2147483647) return 32'sh7FFF_FFFF;
    if (r < -34'sd2147483648) return 32'sh8000_0000;
    return r[31:0];
  endfunction

  logic signed [31:0] wave_x, wave_y, wave_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_x <= '0;
      wave_y <= '0;
      wave_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_X: wave_x <= cfg_data;
        REG_WAVE_Y: wave_y <= cfg_data;
        REG_WAVE_Z: wave_z <= cfg_data;
        default: ;
      endcase
    end
  end

  logic skid_valid;
  logic adv;

  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  // stage 1: products, only the low 40 bits matter for the fractional turn
  logic signed [63:0] mx, my, mz;
  logic               v1;
  logic [39:0]        prod_x, prod_y, prod_z;
  logic signed [31:0] charge1;

  always_comb begin
    mx = 64'(wave_x) * 64'(in_req.pos_x);
    my = 64'(wave_y) * 64'(in_req.pos_y);
    mz = 64'(wave_z) * 64'(in_req.pos_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x  <= mx[39:0];
      prod_y  <= my[39:0];
      prod_z  <= mz[39:0];
      charge1 <= in_req.charge;
    end
  end

  // stage 2: phase, quadrant and residual angle
  logic [39:0]   phase;
  logic [31:0]   a32, qsum, rem;
  logic [1:0]    qbits;
  cordic_stage_t c_in_next, c_in, c_out;

  always_comb begin
    phase           = prod_x + prod_y + prod_z;
    a32             = phase[39:8] & ANGLE_MASK;
    qsum            = a32 + EIGHTH_TURN;
    qbits           = qsum[31:30];
    rem             = a32 - {qbits, 30'd0};
    c_in_next.valid  = v1;
    c_in_next.quad   = quad_t'(qbits);
    c_in_next.charge = charge1;
    c_in_next.x      = CORDIC_X0;
    c_in_next.y      = '0;
    c_in_next.z      = $signed({rem[31], rem});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_in.valid <= 1'b0;
    end else if (adv) begin
      c_in <= c_in_next;
    end
  end

  cwps_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_stage  (c_in),
    .out_stage (c_out)
  );

  // stage 3: quadrant fold and clamp
  logic signed [XY_W-1:0] mc, ms;
  logic                   v3;
  logic signed [31:0]     cos3, sin3, charge3;

  always_comb begin
    case (c_out.quad)
      QUAD_90: begin
        mc = -c_out.y;
        ms = c_out.x;
      end
      QUAD_180: begin
        mc = -c_out.x;
        ms = -c_out.y;
      end
      QUAD_270: begin
        mc = c_out.y;
        ms = -c_out.x;
      end
      default: begin
        mc = c_out.x;
        ms = c_out.y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= c_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos3    <= clamp_unit(mc);
      sin3    <= clamp_unit(ms);
      charge3 <= c_out.charge;
    end
  end

  // stage 4: charge scaling
  logic               v4;
  logic signed [63:0] prod_re, prod_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_re <= 64'(charge3) * 64'(cos3);
      prod_im <= 64'(charge3) * 64'(sin3);
    end
  end

  // rounding feeds the output register and skid
  density_t pipe_res, skid_req;
  logic     emit;

  always_comb begin
    pipe_res.cos_term = round_sat(prod_re);
    pipe_res.sin_term = round_sat(prod_im);
    emit              = v4 && adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || emit;
      skid_valid <= 1'b0;
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_req <= skid_valid ? skid_req : pipe_res;
    end else if (emit) begin
      skid_req <= pipe_res;
    end
  end

endmodule

// ===== design/cwps_checker.sv =====
// ----------------------------------------------------------------------------
// cwps_checker
// Port-level checks on the output handshake, the skid back-pressure and the reset state.
// ----------------------------------------------------------------------------
`include "charge_weighted_phase_sincos_top_assert.svh"

module cwps_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cwps_pkg::density_t out_req
);

  `CWPS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_req), "stalled result changed")
  `CWPS_ASSERT(a_stall_cause, clk, rst, in_stall |-> out_valid && $past(out_valid && out_stall), "input stalled without a held result")
  `CWPS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind charge_weighted_phase_sincos_top cwps_checker u_cwps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_req   (out_req)
);
